// ===== src/ssm_pkg.sv =====
// Shared constants, types and the sequencer state encoding for summary_stats_merge.
// No dependencies; all other files reference this package by scoped names.
package ssm_pkg;

    localparam int NUM_BINS  = 256;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    localparam int BIN_W   = 8;
    localparam int CNT_W   = 32;
    localparam int MEAN_W  = 48;
    localparam int VAR_W   = 64;
    localparam int EXT_W   = 32;
    localparam int ITEM_W  = BIN_W + CNT_W + MEAN_W + VAR_W + 2 * EXT_W;

    // |m1 - M| magnitude, shift-add multiplier operand width
    localparam int MAG_W   = MEAN_W + 1;
    // v + (d*d >> FRAC_BITS), with headroom
    localparam int T_W     = 2 * MAG_W - FRAC_BITS + 2;
    // widest intermediate: sum of two n * t products
    localparam int ACC_W   = T_W + CNT_W + 1;
    // exact total count, also the divisor
    localparam int DIV_W   = CNT_W + 1;
    localparam int STEP_W  = $clog2(ACC_W + 1);

    typedef struct packed {
        logic [EXT_W-1:0]  max;
        logic [EXT_W-1:0]  min;
        logic [VAR_W-1:0]  variance;
        logic [MEAN_W-1:0] mean;
        logic [CNT_W-1:0]  count;
    } agg_t;

    typedef struct packed {
        logic              start;
        logic              div;
        logic              clr;
        logic              sub;
        logic [ACC_W-1:0]  a;
        logic [MAG_W-1:0]  b;
        logic [DIV_W-1:0]  divisor;
    } unit_cmd_t;

    typedef struct packed {
        logic              busy;
        logic [ACC_W-1:0]  acc;
    } unit_sts_t;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_LOAD,
        S_WM1, S_WM1W, S_WM2, S_WM2W, S_DM, S_DMW, S_FIXM,
        S_SQ1, S_SQ1W, S_SQ2, S_SQ2W, S_V1, S_V1W, S_V2, S_V2W,
        S_DV, S_DVW, S_DONE, S_OUT
    } state_t;

endpackage

// ===== src/ssm_store.sv =====
// Per-bin aggregate memory with registered read and per-entry valid bits.
// Depends on ssm_pkg for the entry type and depth.
module ssm_store (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [ssm_pkg::ADDR_W-1:0] rd_addr,
    output ssm_pkg::agg_t             rd_data,
    input  logic                      wr_en,
    input  logic [ssm_pkg::ADDR_W-1:0] wr_addr,
    input  ssm_pkg::agg_t             wr_data
);

    ssm_pkg::agg_t                 mem [ssm_pkg::NUM_BINS];
    logic [ssm_pkg::NUM_BINS-1:0]  valid_reg;
    ssm_pkg::agg_t                 rd_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // never-written entries read with a zero count
    always_comb begin
        rd_data = rd_reg;
        if (!rd_valid_reg) begin
            rd_data.count = '0;
        end
    end

endmodule

// ===== src/ssm_mul_div.sv =====
// Shared shift-add multiply-accumulate and restoring divide unit.
// Depends on ssm_pkg for widths and the command/status structs.
module ssm_mul_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  ssm_pkg::unit_cmd_t  cmd,
    output ssm_pkg::unit_sts_t  sts
);

    logic                            busy_reg, busy_next;
    logic                            div_reg, div_next;
    logic                            sub_reg, sub_next;
    logic [ssm_pkg::ACC_W-1:0]       acc_reg, acc_next;
    logic [ssm_pkg::ACC_W-1:0]       a_reg, a_next;
    logic [ssm_pkg::MAG_W-1:0]       b_reg, b_next;
    logic [ssm_pkg::DIV_W-1:0]       d_reg, d_next;
    logic [ssm_pkg::DIV_W-1:0]       rem_reg, rem_next;
    logic [ssm_pkg::STEP_W-1:0]      cnt_reg, cnt_next;
    logic [ssm_pkg::DIV_W:0]         shifted;
    logic [ssm_pkg::DIV_W:0]         diff;
    logic                            ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg <= div_next;
        sub_reg <= sub_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign shifted = {rem_reg, acc_reg[ssm_pkg::ACC_W-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign ge      = (shifted >= {1'b0, d_reg});

    always_comb begin
        busy_next = busy_reg;
        div_next  = div_reg;
        sub_next  = sub_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (!busy_reg) begin
            if (cmd.start) begin
                busy_next = 1'b1;
                div_next  = cmd.div;
                if (cmd.div) begin
                    acc_next = cmd.a;
                    d_next   = cmd.divisor;
                    rem_next = '0;
                    cnt_next = ssm_pkg::STEP_W'(ssm_pkg::ACC_W);
                end else begin
                    a_next   = cmd.a;
                    b_next   = cmd.b;
                    sub_next = cmd.sub;
                    acc_next = cmd.clr ? '0 : acc_reg;
                end
            end
        end else if (div_reg) begin
            // one quotient bit per cycle, shifted into the accumulator
            rem_next = ge ? diff[ssm_pkg::DIV_W-1:0] : shifted[ssm_pkg::DIV_W-1:0];
            acc_next = {acc_reg[ssm_pkg::ACC_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ssm_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end else begin
            if (b_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (b_reg[0]) begin
                    acc_next = acc_reg + (a_reg ^ {ssm_pkg::ACC_W{sub_reg}})
                             + ssm_pkg::ACC_W'(sub_reg);
                end
                a_next = {a_reg[ssm_pkg::ACC_W-2:0], 1'b0};
                b_next = b_reg >> 1;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.acc  = acc_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && div_reg |-> rem_reg < d_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== src/summary_stats_merge.sv =====
// Top level of summary_stats_merge: stream ports, merge sequencer and result register.
// Depends on ssm_pkg, ssm_store and ssm_mul_div.
// Sequence: when the part or the stored aggregate is empty, m_tvalid is set from S_LOAD,
// after the S_READ state; otherwise the shared unit runs two signed multiplies, one divide,
// two squarings, two multiplies and a second divide, and the result is set from S_DONE.
// Throughput: one transaction at a time; s_tready is high only while idle.
// Reset (aresetn low, synchronous) clears the sequencer, the output valid and all
// per-bin valid bits, so every bin starts with a zero count.
module summary_stats_merge (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // bin, part_count, part_mean, part_variance, part_min, part_max
    input  logic [ssm_pkg::ITEM_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_bin, total_count, total_mean, total_variance, total_min, total_max
    output logic [ssm_pkg::ITEM_W-1:0]  m_tdata,
    // saturated
    output logic [0:0]                  m_tuser
);

    ssm_pkg::state_t state_reg, state_next;

    // captured input transaction
    logic [ssm_pkg::ADDR_W-1:0]  idx_reg, idx_next;
    ssm_pkg::agg_t               part_reg, part_next;

    // merge intermediates
    logic [ssm_pkg::DIV_W-1:0]   total_reg, total_next;
    logic                        neg_reg, neg_next;
    logic [ssm_pkg::MEAN_W-1:0]  mm_reg, mm_next;
    logic [ssm_pkg::MAG_W-1:0]   d1_reg, d1_next;
    logic [ssm_pkg::MAG_W-1:0]   d2_reg, d2_next;
    logic [ssm_pkg::T_W-1:0]     t1_reg, t1_next;
    logic [ssm_pkg::T_W-1:0]     t2_reg, t2_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [ssm_pkg::ITEM_W-1:0]  out_data_reg, out_data_next;
    logic                        out_sat_reg, out_sat_next;

    ssm_pkg::agg_t               agg_rd;
    ssm_pkg::agg_t               wr_data;
    logic                        wr_en;
    ssm_pkg::unit_cmd_t          cmd;
    ssm_pkg::unit_sts_t          sts;

    // combinational helpers
    logic [ssm_pkg::ADDR_W-1:0]  in_idx;
    logic [ssm_pkg::MEAN_W-1:0]  m1_mag, m2_mag, qm, mm_c;
    logic [ssm_pkg::ACC_W-1:0]   s_abs;
    logic [ssm_pkg::MAG_W-1:0]   d1_c, d2_c;
    logic [ssm_pkg::ACC_W-1:0]   sq_scaled;
    ssm_pkg::agg_t               merged;
    logic                        var_sat;

    function automatic logic [ssm_pkg::ITEM_W-1:0] pack_item(
        input logic [ssm_pkg::ADDR_W-1:0] idx,
        input ssm_pkg::agg_t              a
    );
        logic [ssm_pkg::BIN_W-1:0] b8;
        b8 = ssm_pkg::BIN_W'(idx);
        return {a.max, a.min, a.variance, a.mean, a.count, b8};
    endfunction

    function automatic logic [ssm_pkg::MAG_W-1:0] diff_mag(
        input logic [ssm_pkg::MEAN_W-1:0] x,
        input logic [ssm_pkg::MEAN_W-1:0] y
    );
        logic [ssm_pkg::MAG_W-1:0] d;
        d = {x[ssm_pkg::MEAN_W-1], x} - {y[ssm_pkg::MEAN_W-1], y};
        return d[ssm_pkg::MAG_W-1] ? (~d + 1'b1) : d;
    endfunction

    ssm_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (idx_reg),
        .rd_data (agg_rd),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data)
    );

    ssm_mul_div u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ssm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        part_reg     <= part_next;
        total_reg    <= total_next;
        neg_reg      <= neg_next;
        mm_reg       <= mm_next;
        d1_reg       <= d1_next;
        d2_reg       <= d2_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    // bin folds onto the available entries
    assign in_idx = ssm_pkg::ADDR_W'(32'(s_tdata[ssm_pkg::BIN_W-1:0]) % ssm_pkg::NUM_BINS);

    assign m1_mag = agg_rd.mean[ssm_pkg::MEAN_W-1] ? (~agg_rd.mean + 1'b1) : agg_rd.mean;
    assign m2_mag = part_reg.mean[ssm_pkg::MEAN_W-1] ? (~part_reg.mean + 1'b1)
                                                     : part_reg.mean;
    assign s_abs  = sts.acc[ssm_pkg::ACC_W-1] ? (~sts.acc + 1'b1) : sts.acc;

    // mean quotient magnitude never exceeds the larger input magnitude
    assign qm     = sts.acc[ssm_pkg::MEAN_W-1:0];
    assign mm_c   = neg_reg ? (~qm + 1'b1) : qm;
    assign d1_c   = diff_mag(agg_rd.mean, mm_c);
    assign d2_c   = diff_mag(part_reg.mean, mm_c);
    assign sq_scaled = sts.acc >> ssm_pkg::FRAC_BITS;

    assign var_sat = (sts.acc[ssm_pkg::ACC_W-1:ssm_pkg::VAR_W] != '0);

    always_comb begin
        merged.count    = total_reg[ssm_pkg::CNT_W] ? {ssm_pkg::CNT_W{1'b1}}
                                                    : total_reg[ssm_pkg::CNT_W-1:0];
        merged.mean     = mm_reg;
        merged.variance = var_sat ? {ssm_pkg::VAR_W{1'b1}} : sts.acc[ssm_pkg::VAR_W-1:0];
        merged.min      = ($signed(part_reg.min) < $signed(agg_rd.min)) ? part_reg.min
                                                                        : agg_rd.min;
        merged.max      = ($signed(part_reg.max) > $signed(agg_rd.max)) ? part_reg.max
                                                                        : agg_rd.max;
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        part_next      = part_reg;
        total_next     = total_reg;
        neg_next       = neg_reg;
        mm_next        = mm_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;
        wr_en          = 1'b0;
        wr_data        = part_reg;
        s_tready       = 1'b0;
        cmd            = '0;

        case (state_reg)
            ssm_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    idx_next          = in_idx;
                    part_next.count   = s_tdata[39:8];
                    part_next.mean    = s_tdata[87:40];
                    part_next.variance = s_tdata[151:88];
                    part_next.min     = s_tdata[183:152];
                    part_next.max     = s_tdata[215:184];
                    state_next        = ssm_pkg::S_READ;
                end
            end
            ssm_pkg::S_READ: begin
                // store read address settles this cycle
                state_next = ssm_pkg::S_LOAD;
            end
            ssm_pkg::S_LOAD: begin
                total_next = ssm_pkg::DIV_W'(agg_rd.count) + ssm_pkg::DIV_W'(part_reg.count);
                out_sat_next = 1'b0;
                if (part_reg.count == '0) begin
                    // empty part: report current aggregate, zeros when the bin is empty
                    out_data_next  = pack_item(idx_reg, (agg_rd.count == '0) ? '0 : agg_rd);
                    out_valid_next = 1'b1;
                    state_next     = ssm_pkg::S_OUT;
                end else if (agg_rd.count == '0) begin
                    wr_en          = 1'b1;
                    wr_data        = part_reg;
                    out_data_next  = pack_item(idx_reg, part_reg);
                    out_valid_next = 1'b1;
                    state_next     = ssm_pkg::S_OUT;
                end else begin
                    state_next = ssm_pkg::S_WM1;
                end
            end
            ssm_pkg::S_WM1: begin
                cmd.start  = 1'b1;
                cmd.clr    = 1'b1;
                cmd.sub    = agg_rd.mean[ssm_pkg::MEAN_W-1];
                cmd.a      = ssm_pkg::ACC_W'(m1_mag);
                cmd.b      = ssm_pkg::MAG_W'(agg_rd.count);
                state_next = ssm_pkg::S_WM1W;
            end
            ssm_pkg::S_WM1W: begin
                if (!sts.busy) begin
                    state_next = ssm_pkg::S_WM2;
                end
            end
            ssm_pkg::S_WM2: begin
                cmd.start  = 1'b1;
                cmd.sub    = part_reg.mean[ssm_pkg::MEAN_W-1];
                cmd.a      = ssm_pkg::ACC_W'(m2_mag);
                cmd.b      = ssm_pkg::MAG_W'(part_reg.count);
                state_next = ssm_pkg::S_WM2W;
            end
            ssm_pkg::S_WM2W: begin
                if (!sts.busy) begin
                    state_next = ssm_pkg::S_DM;
                end
            end
            ssm_pkg::S_DM: begin
                neg_next    = sts.acc[ssm_pkg::ACC_W-1];
                cmd.start   = 1'b1;
                cmd.div     = 1'b1;
                cmd.a       = s_abs;
                cmd.divisor = total_reg;
                state_next  = ssm_pkg::S_DMW;
            end
            ssm_pkg::S_DMW: begin
                if (!sts.busy) begin
                    state_next = ssm_pkg::S_FIXM;
                end
            end
            ssm_pkg::S_FIXM: begin
                mm_next    = mm_c;
                d1_next    = d1_c;
                d2_next    = d2_c;
                state_next = ssm_pkg::S_SQ1;
            end
            ssm_pkg::S_SQ1: begin
                cmd.start  = 1'b1;
                cmd.clr    = 1'b1;
                cmd.a      = ssm_pkg::ACC_W'(d1_reg);
                cmd.b      = d1_reg;
                state_next = ssm_pkg::S_SQ1W;
            end
            ssm_pkg::S_SQ1W: begin
                if (!sts.busy) begin
                    state_next = ssm_pkg::S_SQ2;
                end
            end
            ssm_pkg::S_SQ2: begin
                t1_next    = ssm_pkg::T_W'(sq_scaled) + ssm_pkg::T_W'(agg_rd.variance);
                cmd.start  = 1'b1;
                cmd.clr    = 1'b1;
                cmd.a      = ssm_pkg::ACC_W'(d2_reg);
                cmd.b      = d2_reg;
                state_next = ssm_pkg::S_SQ2W;
            end
            ssm_pkg::S_SQ2W: begin
                if (!sts.busy) begin
                    state_next = ssm_pkg::S_V1;
                end
            end
            ssm_pkg::S_V1: begin
                t2_next    = ssm_pkg::T_W'(sq_scaled) + ssm_pkg::T_W'(part_reg.variance);
                cmd.start  = 1'b1;
                cmd.clr    = 1'b1;
                cmd.a      = ssm_pkg::ACC_W'(t1_reg);
                cmd.b      = ssm_pkg::MAG_W'(agg_rd.count);
                state_next = ssm_pkg::S_V1W;
            end
            ssm_pkg::S_V1W: begin
                if (!sts.busy) begin
                    state_next = ssm_pkg::S_V2;
                end
            end
            ssm_pkg::S_V2: begin
                cmd.start  = 1'b1;
                cmd.a      = ssm_pkg::ACC_W'(t2_reg);
                cmd.b      = ssm_pkg::MAG_W'(part_reg.count);
                state_next = ssm_pkg::S_V2W;
            end
            ssm_pkg::S_V2W: begin
                if (!sts.busy) begin
                    state_next = ssm_pkg::S_DV;
                end
            end
            ssm_pkg::S_DV: begin
                cmd.start   = 1'b1;
                cmd.div     = 1'b1;
                cmd.a       = sts.acc;
                cmd.divisor = total_reg;
                state_next  = ssm_pkg::S_DVW;
            end
            ssm_pkg::S_DVW: begin
                if (!sts.busy) begin
                    state_next = ssm_pkg::S_DONE;
                end
            end
            ssm_pkg::S_DONE: begin
                wr_en          = 1'b1;
                wr_data        = merged;
                out_data_next  = pack_item(idx_reg, merged);
                out_sat_next   = total_reg[ssm_pkg::CNT_W] | var_sat;
                out_valid_next = 1'b1;
                state_next     = ssm_pkg::S_OUT;
            end
            ssm_pkg::S_OUT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    state_next     = ssm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ssm_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while one is in flight");
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result waits");
    a_empty_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[39:8] == '0) |-> (m_tdata[215:40] == '0) && !m_tuser[0])
        else $error("empty aggregate reported with nonzero fields");
`endif

endmodule

// ===== test/summary_stats_merge_tb.sv =====
// Self-checking testbench for summary_stats_merge: random and directed merges
// of partial summaries, compared against a per-bin merge predictor.
// Depends on ssm_pkg and the summary_stats_merge RTL.
`timescale 1ns / 100ps

module summary_stats_merge_tb;

    localparam int N_RANDOM   = 1200;
    localparam int QUIET_TAIL = 100;      // no idling for the last transactions
    localparam int WDOG_LIMIT = 20000;    // cycles without any accepted transaction
    localparam int LONG_HOLD  = 2000;     // receiver hold-off, cycles

    typedef struct packed {
        logic [ssm_pkg::EXT_W-1:0]  pmax;
        logic [ssm_pkg::EXT_W-1:0]  pmin;
        logic [ssm_pkg::VAR_W-1:0]  pvar;
        logic [ssm_pkg::MEAN_W-1:0] pmean;
        logic [ssm_pkg::CNT_W-1:0]  pcount;
        logic [ssm_pkg::BIN_W-1:0]  pbin;
    } part_t;

    typedef struct packed {
        logic                       sat;
        logic [ssm_pkg::EXT_W-1:0]  tmax;
        logic [ssm_pkg::EXT_W-1:0]  tmin;
        logic [ssm_pkg::VAR_W-1:0]  tvar;
        logic [ssm_pkg::MEAN_W-1:0] tmean;
        logic [ssm_pkg::CNT_W-1:0]  tcount;
        logic [ssm_pkg::BIN_W-1:0]  tbin;
    } merged_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [ssm_pkg::ITEM_W-1:0]   s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [ssm_pkg::ITEM_W-1:0]   m_tdata;
    logic [0:0]                   m_tuser;

    summary_stats_merge u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predictor copy of the per-bin aggregates
    logic [ssm_pkg::CNT_W-1:0]  bin_count [ssm_pkg::NUM_BINS];
    logic [ssm_pkg::MEAN_W-1:0] bin_mean  [ssm_pkg::NUM_BINS];
    logic [ssm_pkg::VAR_W-1:0]  bin_var   [ssm_pkg::NUM_BINS];
    logic [ssm_pkg::EXT_W-1:0]  bin_min   [ssm_pkg::NUM_BINS];
    logic [ssm_pkg::EXT_W-1:0]  bin_max   [ssm_pkg::NUM_BINS];

    part_t   pending_parts[$];
    merged_t expected_aggs[$];
    int      mismatches  = 0;
    int      sent        = 0;
    int      total_parts = 0;
    int      results     = 0;
    int      idle_cycles = 0;
    bit      tail_quiet  = 0;

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    // Fold one part into its bin, return the updated aggregate.
    function automatic merged_t merge_part(part_t p);
        merged_t r;
        int b;
        logic [32:0] tot;
        logic signed [159:0] n1w, n2w, m1w, m2w, sum, mm, d1, d2;
        logic [159:0] dm1, dm2, vsum, vq;
        b = p.pbin % ssm_pkg::NUM_BINS;
        r.sat = 1'b0;
        if (p.pcount != 0 && bin_count[b] == 0) begin
            bin_count[b] = p.pcount;
            bin_mean[b]  = p.pmean;
            bin_var[b]   = p.pvar;
            bin_min[b]   = p.pmin;
            bin_max[b]   = p.pmax;
        end else if (p.pcount != 0) begin
            tot = {1'b0, bin_count[b]} + {1'b0, p.pcount};
            n1w = $signed({128'b0, bin_count[b]});
            n2w = $signed({128'b0, p.pcount});
            m1w = {{112{bin_mean[b][ssm_pkg::MEAN_W-1]}}, bin_mean[b]};
            m2w = {{112{p.pmean[ssm_pkg::MEAN_W-1]}}, p.pmean};
            sum = n1w * m1w + n2w * m2w;
            // signed divide truncates toward zero
            mm  = sum / $signed({127'b0, tot});
            d1  = m1w - mm;
            d2  = m2w - mm;
            dm1 = d1 < 0 ? -d1 : d1;
            dm2 = d2 < 0 ? -d2 : d2;
            vsum = {128'b0, bin_count[b]}
                 * ({96'b0, bin_var[b]} + ((dm1 * dm1) >> ssm_pkg::FRAC_BITS))
                 + {128'b0, p.pcount}
                 * ({96'b0, p.pvar} + ((dm2 * dm2) >> ssm_pkg::FRAC_BITS));
            vq = vsum / {127'b0, tot};
            if (vq[159:64] != 0) begin
                bin_var[b] = '1;
                r.sat = 1'b1;
            end else begin
                bin_var[b] = vq[63:0];
            end
            bin_mean[b] = mm[ssm_pkg::MEAN_W-1:0];
            if ($signed(p.pmax) > $signed(bin_max[b])) bin_max[b] = p.pmax;
            if ($signed(p.pmin) < $signed(bin_min[b])) bin_min[b] = p.pmin;
            if (tot[32]) begin
                bin_count[b] = '1;
                r.sat = 1'b1;
            end else begin
                bin_count[b] = tot[31:0];
            end
        end
        r.tbin   = ssm_pkg::BIN_W'(b);
        r.tcount = bin_count[b];
        r.tmean  = bin_mean[b];
        r.tvar   = bin_var[b];
        r.tmin   = bin_min[b];
        r.tmax   = bin_max[b];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driver: pops parts from the pending queue, random idle bursts
    // ---------------------------------------------------------------
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_aggs.push_back(merge_part(part_t'(s_tdata)));
                sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 4);
                    s_tvalid <= 1'b0;
                end else if (pending_parts.size() != 0) begin
                    s_tdata  <= pending_parts.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: backpressure, one long hold-off, result checking
    // ---------------------------------------------------------------
    int  sink_hold = 0;
    bit  long_done = 0;
    always @(posedge aclk) begin
        merged_t got, exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                results++;
                if (expected_aggs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %h", got);
                end else begin
                    exp_r = expected_aggs.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d bin %0d:", results, exp_r.tbin);
                            $display("  exp cnt %h mean %h var %h min %h max %h sat %b",
                                     exp_r.tcount, exp_r.tmean, exp_r.tvar,
                                     exp_r.tmin, exp_r.tmax, exp_r.sat);
                            $display("  got cnt %h mean %h var %h min %h max %h sat %b",
                                     got.tcount, got.tmean, got.tvar,
                                     got.tmin, got.tmax, got.sat);
                        end
                    end
                end
            end
            // long stall once, while the driver keeps offering parts
            if (!long_done && results == 40) begin
                long_done = 1;
                sink_hold = LONG_HOLD;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
                sink_hold = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: counts cycles with no accepted transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (total_parts != 0 && sent >= total_parts - QUIET_TAIL) tail_quiet <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    bit written [ssm_pkg::NUM_BINS];

    function automatic part_t mk(int b, logic [31:0] c, logic [47:0] m, logic [63:0] v,
                                 logic [31:0] lo, logic [31:0] hi);
        part_t p;
        p.pbin = ssm_pkg::BIN_W'(b);
        p.pcount = c; p.pmean = m; p.pvar = v; p.pmin = lo; p.pmax = hi;
        if (c != 0) written[b] = 1;
        return p;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        part_t p;
        int b;
        logic [31:0] c, x, y;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        for (int i = 0; i < ssm_pkg::NUM_BINS; i++) begin
            bin_count[i] = '0; bin_mean[i] = '0; bin_var[i] = '0;
            bin_min[i] = '0; bin_max[i] = '0; written[i] = 0;
        end

        // directed: copy into empty bin, extremes, saturation, empty part
        pending_parts.push_back(mk(0, 1, 48'h7FFF_FFFF_FFFF, '0, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_parts.push_back(mk(0, 1, 48'h8000_0000_0000, '0, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_parts.push_back(mk(0, 0, 48'h1234, 64'h5, 32'h1, 32'h2));
        pending_parts.push_back(mk(255, 32'hFFFF_FFFF, 48'h8000_0000_0000, '1,
                                   32'h8000_0000, 32'h8000_0000));
        pending_parts.push_back(mk(255, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, '1,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_parts.push_back(mk(255, 1, '0, '0, '0, '0));
        pending_parts.push_back(mk(1, 32'h8000_0000, 48'hFFFF_FFFF_0000, 64'h1_0000,
                                   32'hFFFF_FFF0, 32'h10));
        pending_parts.push_back(mk(1, 3, 48'h0000_0003_8000, 64'h8000_0000_0000_0000,
                                   32'h20, 32'hFFFF_FFE0));
        pending_parts.push_back(mk(1, 0, '0, '0, '0, '0));
        pending_parts.push_back(mk(2, 7, 48'hFFFF_FFFF_FFFF, 64'h3, 32'h5, 32'h4));
        pending_parts.push_back(mk(2, 7, 48'h1, 64'h3, 32'h4, 32'h5));
        pending_parts.push_back(mk(3, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, '0, '0, '0));
        pending_parts.push_back(mk(3, 1, 48'h8000_0000_0000, '0, '0, '0));

        // random: mostly a few hot bins so parts really merge
        for (int i = 0; i < N_RANDOM; i++) begin
            b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0:       c = $urandom();
                1:       c = written[b] ? 32'd0 : 32'd1;
                2:       c = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: c = $urandom_range(1, 1000);
            endcase
            x = $urandom(); y = $urandom();
            p = mk(b, c, 48'({$urandom(), $urandom()}),
                   ($urandom_range(0, 3) == 0) ? rnd64() : rnd64() >> $urandom_range(8, 60),
                   $urandom_range(0, 9) == 0 ? y : ($signed(x) < $signed(y) ? x : y),
                   $urandom_range(0, 9) == 0 ? x : ($signed(x) < $signed(y) ? y : x));
            pending_parts.push_back(p);
        end
        total_parts = pending_parts.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_parts.size() != 0 || s_tvalid || expected_aggs.size() != 0)
            @(posedge aclk);
        repeat (600) @(posedge aclk);

        if (mismatches == 0 && expected_aggs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
